### sv/assert_macros.svh
// Assertion macros shared by the root finder RTL.
// Depends on nothing; users must have clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRF_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PRF_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/prf_pkg.sv
// Package of the polynomial root finder: sizes, register codes, states and
// the command and status structs between controller and datapath.
// Depends on nothing.
package prf_pkg;

	localparam int MAX_DEGREE = 8;
	localparam int NCOEF      = MAX_DEGREE + 1;
	localparam int CIDX_W     = $clog2(NCOEF);
	localparam int RIDX_W     = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
	localparam int CNT_W      = $clog2(MAX_DEGREE + 3);
	localparam int DIV_STEPS  = 72;
	localparam int DIVC_W     = $clog2(DIV_STEPS);

	localparam logic signed [31:0] ROOT_MIN_RST = -32'sd184549376;
	localparam logic signed [31:0] ROOT_MAX_RST = 32'sd184549376;
	localparam logic [20:0]        TOL_RST      = 21'd1;

	typedef enum logic [1:0] {
		CFG_ROOT_MIN  = 2'd0,
		CFG_ROOT_MAX  = 2'd1,
		CFG_TOLERANCE = 2'd2
	} cfg_reg_t;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_CHECK,
		ST_ERR,
		ST_COPY,
		ST_SCALE,
		ST_DIV_INIT,
		ST_DIV,
		ST_DIV_END,
		ST_B_LEFT,
		ST_B_RIGHT,
		ST_E_START,
		ST_E_MLO,
		ST_E_MHI,
		ST_E_MAG,
		ST_E_ADD,
		ST_B_DECIDE,
		ST_B_TEST,
		ST_LVL_END,
		ST_EMIT
	} prf_state_t;

	typedef struct packed {
		logic              load;
		logic              clr_cnt;
		logic              copy_d;
		logic              scale;
		logic              div_init;
		logic              div_step;
		logic              div_end;
		logic              ld_left;
		logic              ld_right;
		logic              first;
		logic              last;
		logic              x_mid;
		logic              acc_init;
		logic              mul_lo;
		logic              mul_hi;
		logic              mag;
		logic              acc_add;
		logic              dec_init;
		logic              dec_upd;
		logic              wr_cur;
		logic              lvl_end;
		logic              out_err;
		logic [CIDX_W-1:0] didx;
		logic [CIDX_W-1:0] factor;
		logic [RIDX_W-1:0] ridx;
	} prf_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic             lead_zero;
		logic             brk_done;
	} prf_stat_t;

endpackage

### sv/prf_dp.sv
// Datapath of the root finder: coefficient and derivative stores, root
// stores, Horner evaluator, bit-serial divider and bisection bracket.
// Depends on prf_pkg.
module prf_dp import prf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] in_coef,
	input  logic        cfg_wr,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  prf_cmd_t    cmd,
	output prf_stat_t   stat,
	output logic [31:0] out_root
);

	localparam logic signed [64:0] ACC_HI  = 65'sd4611686018427387904;
	localparam logic signed [64:0] ACC_LO  = -65'sd4611686018427387904;
	localparam logic [62:0]        MAG_LIM = 63'd4611686018427387904;
	localparam logic signed [52:0] D_HI    = 53'sd140737488355327;
	localparam logic signed [52:0] D_LO    = -53'sd140737488355328;

	logic signed [31:0] rmin_q, rmax_q;
	logic [20:0]        tol_q;
	logic [CNT_W-1:0]   cnt_q;

	logic signed [31:0] coef_q  [NCOEF];
	logic signed [47:0] deriv_q [NCOEF];
	logic signed [31:0] prev_q  [MAX_DEGREE];
	logic signed [31:0] cur_q   [MAX_DEGREE];

	logic signed [63:0] acc_q, prod_q;
	logic signed [31:0] x_q, lft_q, rgt_q, neg_q, pos_q;
	logic [63:0]        plo_q;
	logic [62:0]        phi_q;

	logic [71:0]        dvd_q;
	logic [47:0]        rem_q, dmag_q;
	logic [30:0]        quo_q;
	logic               ovf_q, dneg_q, dzero_q;

	logic signed [47:0] dsel;
	logic signed [52:0] sc_prod;
	logic signed [47:0] sc_res;
	logic [63:0]        acc_mag;
	logic [31:0]        x_mag, mul_a;
	logic [63:0]        mul_p;
	logic [62:0]        mag_sum, mag_val;
	logic signed [64:0] add_sum;
	logic signed [63:0] add_res;
	logic signed [32:0] br_diff, br_sum;
	logic [32:0]        br_abs;
	logic [20:0]        tol_eff;
	logic signed [31:0] mid;
	logic [47:0]        nmag, dmag;
	logic [48:0]        r2;
	logic               qbit;
	logic [31:0]        div_res;
	logic signed [31:0] left_val, right_val;

	// Configuration registers and the coefficient count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rmin_q <= ROOT_MIN_RST;
			rmax_q <= ROOT_MAX_RST;
			tol_q  <= TOL_RST;
			cnt_q  <= '0;
		end else begin
			if (cfg_wr) begin
				case (cfg_index)
					CFG_ROOT_MIN:  rmin_q <= cfg_data;
					CFG_ROOT_MAX:  rmax_q <= cfg_data;
					CFG_TOLERANCE: tol_q  <= cfg_data[20:0];
					default: ;
				endcase
			end
			if (cmd.clr_cnt) begin
				cnt_q <= '0;
			end else if (cmd.load && cnt_q < CNT_W'(NCOEF + 1)) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// Derivative scaling: one coefficient times its power factor, saturated.
	always_comb begin
		dsel    = deriv_q[cmd.didx];
		sc_prod = dsel * $signed({1'b0, cmd.factor});
		if (sc_prod > D_HI) begin
			sc_res = 48'sh7FFF_FFFF_FFFF;
		end else if (sc_prod < D_LO) begin
			sc_res = 48'sh8000_0000_0000;
		end else begin
			sc_res = sc_prod[47:0];
		end
	end

	// Horner step pieces: magnitudes, shared multiplier, scaling and sum.
	always_comb begin
		acc_mag = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
		x_mag   = x_q[31] ? 32'(-x_q) : 32'(x_q);
		mul_a   = cmd.mul_hi ? {1'b0, acc_mag[62:32]} : acc_mag[31:0];
		mul_p   = 64'(mul_a) * 64'(x_mag);
		mag_sum = {1'b0, phi_q[53:0], 8'd0} + {23'd0, plo_q[63:24]};
		if (|phi_q[62:54] || mag_sum > MAG_LIM) begin
			mag_val = MAG_LIM;
		end else begin
			mag_val = mag_sum;
		end
		add_sum = {prod_q[63], prod_q} + 65'(dsel);
		if (add_sum > ACC_HI) begin
			add_res = ACC_HI[63:0];
		end else if (add_sum < ACC_LO) begin
			add_res = ACC_LO[63:0];
		end else begin
			add_res = add_sum[63:0];
		end
	end

	// Bracket width test and floor midpoint.
	always_comb begin
		tol_eff = (tol_q < 21'd2) ? 21'd2 : tol_q;
		br_diff = 33'(neg_q) - 33'(pos_q);
		br_abs  = br_diff[32] ? 33'(-br_diff) : 33'(br_diff);
		br_sum  = 33'(neg_q) + 33'(pos_q);
		mid     = br_sum[32:1];
	end

	// Divider step and result formatting for the linear level.
	always_comb begin
		nmag = deriv_q[1][47] ? 48'(-deriv_q[1]) : 48'(deriv_q[1]);
		dmag = deriv_q[0][47] ? 48'(-deriv_q[0]) : 48'(deriv_q[0]);
		r2   = {rem_q, dvd_q[71]};
		qbit = (r2 >= {1'b0, dmag_q});
		if (dzero_q) begin
			div_res = '0;
		end else if (ovf_q) begin
			div_res = dneg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			div_res = dneg_q ? 32'(-{1'b0, quo_q}) : {1'b0, quo_q};
		end
	end

	// Bracket end selection from the previous level's roots.
	always_comb begin
		left_val  = cmd.first ? rmin_q : prev_q[cmd.ridx];
		right_val = cmd.last ? rmax_q : prev_q[cmd.ridx];
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load && cnt_q < CNT_W'(NCOEF)) begin
			coef_q[cnt_q[CIDX_W-1:0]] <= in_coef;
		end
		if (cmd.copy_d) begin
			for (int i = 0; i < NCOEF; i++) begin
				deriv_q[i] <= 48'(coef_q[i]);
			end
		end
		if (cmd.scale) begin
			deriv_q[cmd.didx] <= sc_res;
		end
		if (cmd.div_init) begin
			dvd_q   <= {nmag, 24'd0};
			rem_q   <= '0;
			quo_q   <= '0;
			ovf_q   <= 1'b0;
			dmag_q  <= dmag;
			dzero_q <= (deriv_q[0] == '0);
			dneg_q  <= (deriv_q[1] != '0) && (deriv_q[1][47] == deriv_q[0][47]);
		end
		if (cmd.div_step) begin
			rem_q <= qbit ? 48'(r2 - {1'b0, dmag_q}) : r2[47:0];
			dvd_q <= {dvd_q[70:0], 1'b0};
			quo_q <= {quo_q[29:0], qbit};
			ovf_q <= ovf_q | quo_q[30];
		end
		if (cmd.div_end) begin
			prev_q[0] <= div_res;
		end
		if (cmd.ld_left) begin
			lft_q <= left_val;
			x_q   <= left_val;
		end
		if (cmd.ld_right) begin
			rgt_q <= right_val;
		end
		if (cmd.x_mid) begin
			x_q <= mid;
		end
		if (cmd.acc_init) begin
			acc_q <= 64'(deriv_q[0]);
		end
		if (cmd.mul_lo) begin
			plo_q <= mul_p;
		end
		if (cmd.mul_hi) begin
			phi_q <= mul_p[62:0];
		end
		if (cmd.mag) begin
			prod_q <= (acc_q[63] ^ x_q[31]) ? -$signed({1'b0, mag_val}) : $signed({1'b0, mag_val});
		end
		if (cmd.acc_add) begin
			acc_q <= add_res;
		end
		if (cmd.dec_init) begin
			if (acc_q[63]) begin
				neg_q <= lft_q;
				pos_q <= rgt_q;
			end else begin
				neg_q <= rgt_q;
				pos_q <= lft_q;
			end
		end
		if (cmd.dec_upd) begin
			if (!acc_q[63] && acc_q != '0) begin
				pos_q <= x_q;
			end else begin
				neg_q <= x_q;
			end
		end
		if (cmd.wr_cur) begin
			cur_q[cmd.ridx] <= pos_q;
		end
		if (cmd.lvl_end) begin
			for (int i = 0; i < MAX_DEGREE; i++) begin
				prev_q[i] <= cur_q[i];
			end
		end
	end

	// Status to the controller and result data.
	always_comb begin
		stat.cnt       = cnt_q;
		stat.lead_zero = (coef_q[0] == '0);
		stat.brk_done  = (br_abs < {12'd0, tol_eff});
		out_root       = cmd.out_err ? 32'd0 : prev_q[cmd.ridx];
	end

endmodule

### sv/prf_ctrl.sv
// Controller of the root finder: sequences loading, derivative building,
// the linear division, bisection with Horner evaluation and result output.
// Depends on prf_pkg.
module prf_ctrl import prf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_last,
	output logic      in_ready,
	output logic      out_valid,
	output logic      out_last,
	output logic      out_bad,
	input  logic      out_ready,
	input  prf_stat_t stat,
	output prf_cmd_t  cmd
);

	prf_state_t        state_q, state_d;
	logic [CIDX_W-1:0] n_q, n_d, k_q, k_d, deg_q, deg_d, bi_q, bi_d, hi_q, hi_d;
	logic [RIDX_W-1:0] ri_q, ri_d;
	logic [DIVC_W-1:0] it_q, it_d;
	logic              init_q, init_d;
	logic [CIDX_W-1:0] ri_ext;
	logic              bad;

	// State and loop counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			n_q     <= '0;
			k_q     <= '0;
			deg_q   <= '0;
			bi_q    <= '0;
			hi_q    <= '0;
			ri_q    <= '0;
			it_q    <= '0;
			init_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			n_q     <= n_d;
			k_q     <= k_d;
			deg_q   <= deg_d;
			bi_q    <= bi_d;
			hi_q    <= hi_d;
			ri_q    <= ri_d;
			it_q    <= it_d;
			init_q  <= init_d;
		end
	end

	// Next state, counters and datapath commands.
	always_comb begin
		state_d   = state_q;
		n_d       = n_q;
		k_d       = k_q;
		deg_d     = deg_q;
		bi_d      = bi_q;
		hi_d      = hi_q;
		ri_d      = ri_q;
		it_d      = it_q;
		init_d    = init_q;
		cmd       = '0;
		cmd.ridx  = ri_q;
		cmd.didx  = bi_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		out_last  = 1'b0;
		out_bad   = 1'b0;
		ri_ext    = CIDX_W'(ri_q);
		bad       = (stat.cnt < CNT_W'(2)) || (stat.cnt > CNT_W'(NCOEF)) || stat.lead_zero;

		case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				if (in_valid && in_last) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.clr_cnt = 1'b1;
				n_d         = CIDX_W'(stat.cnt - CNT_W'(1));
				k_d         = CIDX_W'(1);
				state_d     = bad ? ST_ERR : ST_COPY;
			end
			ST_ERR: begin
				out_valid   = 1'b1;
				out_last    = 1'b1;
				out_bad     = 1'b1;
				cmd.out_err = 1'b1;
				if (out_ready) begin
					state_d = ST_LOAD;
				end
			end
			ST_COPY: begin
				cmd.copy_d = 1'b1;
				deg_d      = n_q;
				bi_d       = '0;
				ri_d       = '0;
				if (n_q != k_q) begin
					state_d = ST_SCALE;
				end else begin
					state_d = (k_q == CIDX_W'(1)) ? ST_DIV_INIT : ST_B_LEFT;
				end
			end
			// One coefficient of the current derivative pass per cycle.
			ST_SCALE: begin
				cmd.scale  = 1'b1;
				cmd.factor = deg_q - bi_q;
				if (bi_q == deg_q - CIDX_W'(1)) begin
					bi_d  = '0;
					deg_d = deg_q - CIDX_W'(1);
					if (deg_q - CIDX_W'(1) == k_q) begin
						state_d = (k_q == CIDX_W'(1)) ? ST_DIV_INIT : ST_B_LEFT;
					end
				end else begin
					bi_d = bi_q + CIDX_W'(1);
				end
			end
			ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				it_d         = '0;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (it_q == DIVC_W'(DIV_STEPS - 1)) begin
					state_d = ST_DIV_END;
				end else begin
					it_d = it_q + DIVC_W'(1);
				end
			end
			ST_DIV_END: begin
				cmd.div_end = 1'b1;
				ri_d        = '0;
				if (n_q == CIDX_W'(1)) begin
					state_d = ST_EMIT;
				end else begin
					k_d     = CIDX_W'(2);
					state_d = ST_COPY;
				end
			end
			ST_B_LEFT: begin
				cmd.ld_left = 1'b1;
				cmd.first   = (ri_q == '0);
				cmd.ridx    = ri_q - RIDX_W'(1);
				init_d      = 1'b1;
				state_d     = ST_B_RIGHT;
			end
			ST_B_RIGHT: begin
				cmd.ld_right = 1'b1;
				cmd.last     = (ri_ext == k_q - CIDX_W'(1));
				state_d      = ST_E_START;
			end
			// Horner evaluation at x over the current level's coefficients.
			ST_E_START: begin
				cmd.acc_init = 1'b1;
				hi_d         = CIDX_W'(1);
				state_d      = ST_E_MLO;
			end
			ST_E_MLO: begin
				cmd.mul_lo = 1'b1;
				state_d    = ST_E_MHI;
			end
			ST_E_MHI: begin
				cmd.mul_hi = 1'b1;
				state_d    = ST_E_MAG;
			end
			ST_E_MAG: begin
				cmd.mag = 1'b1;
				state_d = ST_E_ADD;
			end
			ST_E_ADD: begin
				cmd.acc_add = 1'b1;
				cmd.didx    = hi_q;
				if (hi_q == k_q) begin
					state_d = ST_B_DECIDE;
				end else begin
					hi_d    = hi_q + CIDX_W'(1);
					state_d = ST_E_MLO;
				end
			end
			ST_B_DECIDE: begin
				cmd.dec_init = init_q;
				cmd.dec_upd  = !init_q;
				init_d       = 1'b0;
				state_d      = ST_B_TEST;
			end
			ST_B_TEST: begin
				if (stat.brk_done) begin
					cmd.wr_cur = 1'b1;
					if (ri_ext == k_q - CIDX_W'(1)) begin
						state_d = ST_LVL_END;
					end else begin
						ri_d    = ri_q + RIDX_W'(1);
						state_d = ST_B_LEFT;
					end
				end else begin
					cmd.x_mid = 1'b1;
					state_d   = ST_E_START;
				end
			end
			ST_LVL_END: begin
				cmd.lvl_end = 1'b1;
				ri_d        = '0;
				if (k_q == n_q) begin
					state_d = ST_EMIT;
				end else begin
					k_d     = k_q + CIDX_W'(1);
					state_d = ST_COPY;
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				out_last  = (ri_ext == n_q - CIDX_W'(1));
				if (out_ready) begin
					if (out_last) begin
						state_d = ST_LOAD;
					end else begin
						ri_d = ri_q + RIDX_W'(1);
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

endmodule

### sv/polynomial_real_root_finder.sv
// Sequence: the coefficients are loaded and checked, then for each level the
// derivative is built; level one is solved by the linear division, and each level
// above one finds its roots by bisection halvings down to the tolerance and closes;
// roots then leave one a cycle while m_tready is held high.
// Throughput: one polynomial at a time, set by the shared Horner multiplier loop.
// Reset: arst_n clears control state and loads the default bounds and tolerance;
// coefficient, derivative and root stores are left undefined until written.
`include "assert_macros.svh"

module polynomial_real_root_finder import prf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] coefficient
	input  logic        s_tlast,   // last_coefficient
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] root
	output logic        m_tlast,   // last_root
	output logic        m_tuser,   // [0] bad_input
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	prf_cmd_t  cmd;
	prf_stat_t stat;

	// Configuration is always taken.
	assign cfg_ready = 1'b1;

	prf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_last   (s_tlast),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_last  (m_tlast),
		.out_bad   (m_tuser),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	prf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_coef   (s_tdata),
		.cfg_wr    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_root  (m_tdata)
	);

	// Input and output sides are never open together.
	`PRF_ASSERT_IMP(a_no_overlap, s_tready, !m_tvalid, "input and output active together")
	// An error result is a single zero result that ends the run.
	`PRF_ASSERT_IMP(a_err_form, m_tvalid && m_tuser, m_tlast && (m_tdata == 32'd0),
		"malformed error result")
	// After the final transfer of a run the block takes coefficients again.
	`PRF_ASSERT_NXT(a_back_to_load, m_tvalid && m_tready && m_tlast, s_tready,
		"not ready for input after final result")

endmodule

### tb/prf_root_checker.sv
// Checker for the polynomial root finder: watches the coefficient, root and
// register channels, predicts every root and compares it field by field.
// Depends on prf_pkg for the register codes, sizes and reset values.
module prf_root_checker import prf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        m_tlast,
	input  logic        m_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          roots_pending
);

	localparam longint ACC_LIM = 64'sd1 <<< 62;
	localparam longint DER_MAX = (64'sd1 <<< 47) - 1;
	localparam longint DER_MIN = -(64'sd1 <<< 47);

	typedef struct {
		logic [31:0] root;
		logic        last;
		logic        bad;
	} root_result_t;

	root_result_t root_q[$];
	longint       coef_mem[NCOEF];
	longint       deriv_mem[NCOEF];
	longint       lower_roots[MAX_DEGREE];
	longint       upper_roots[MAX_DEGREE];
	int           coef_cnt;
	longint       bound_lo;
	longint       bound_hi;
	longint       stop_width;
	int           n_fail;

	function automatic longint clamp(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Product scaled down by 2^24, truncated toward zero, saturated at 2^62.
	function automatic longint mul_q24(longint acc, longint x);
		longint unsigned m, u, plo, phi, mag;
		m = (acc < 0) ? longint'(-acc) : acc;
		u = (x < 0) ? longint'(-x) : x;
		plo = (m & 64'hFFFF_FFFF) * u;
		phi = (m >> 32) * u;
		if (phi >= (64'd1 << 54)) begin
			mag = ACC_LIM;
		end else begin
			mag = (phi << 8) + (plo >> 24);
			if (mag > ACC_LIM)
				mag = ACC_LIM;
		end
		return ((acc < 0) != (x < 0)) ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic longint horner(int deg, longint x);
		longint acc;
		acc = deriv_mem[0];
		for (int i = 1; i <= deg; i++)
			acc = clamp(mul_q24(acc, x) + deriv_mem[i], -ACC_LIM, ACC_LIM);
		return acc;
	endfunction

	// Derivative of the stored polynomial taken down to degree k.
	function automatic void form_level(int n, int k);
		for (int i = 0; i <= n; i++)
			deriv_mem[i] = coef_mem[i];
		for (int deg = n; deg > k; deg--)
			for (int i = 0; i < deg; i++)
				deriv_mem[i] = clamp(deriv_mem[i] * longint'(deg - i), DER_MIN, DER_MAX);
	endfunction

	function automatic longint solve_linear();
		longint num, den;
		longint unsigned nm, dm, ip, r, frac, mag;
		logic neg;
		num = deriv_mem[1];
		den = deriv_mem[0];
		nm = (num < 0) ? longint'(-num) : num;
		dm = (den < 0) ? longint'(-den) : den;
		neg = (num != 0) && ((num < 0) == (den < 0));
		frac = 0;
		if (dm == 0)
			return 0;
		ip = nm / dm;
		if (ip >= 128)
			return neg ? -64'sd2147483648 : 64'sd2147483647;
		r = nm % dm;
		for (int b = 0; b < 24; b++) begin
			r = r << 1;
			frac = frac << 1;
			if (r >= dm) begin
				r = r - dm;
				frac = frac | 1;
			end
		end
		mag = (ip << 24) | frac;
		return neg ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic longint half_floor(longint s);
		return (s >= 0) ? s / 2 : -((-s + 1) / 2);
	endfunction

	function automatic longint bisect(int deg, longint left, longint right);
		longint neg_end, pos_end, width, mid, tol;
		tol = (stop_width < 2) ? 2 : stop_width;
		if (horner(deg, left) < 0) begin
			neg_end = left;
			pos_end = right;
		end else begin
			neg_end = right;
			pos_end = left;
		end
		forever begin
			width = neg_end - pos_end;
			if (width < 0)
				width = -width;
			if (width < tol)
				break;
			mid = half_floor(neg_end + pos_end);
			if (horner(deg, mid) > 0)
				pos_end = mid;
			else
				neg_end = mid;
		end
		return pos_end;
	endfunction

	// One accepted coefficient; a constant term solves the stored polynomial.
	function automatic void take_coefficient(logic [31:0] data, logic is_last);
		int n;
		root_result_t r;
		if (coef_cnt < NCOEF)
			coef_mem[coef_cnt] = longint'($signed(data));
		if (coef_cnt < NCOEF + 1)
			coef_cnt++;
		if (!is_last)
			return;
		n = coef_cnt - 1;
		coef_cnt = 0;
		if (n < 1 || n > MAX_DEGREE || coef_mem[0] == 0) begin
			r.root = '0;
			r.last = 1'b1;
			r.bad  = 1'b1;
			root_q = {root_q, r};
			return;
		end
		form_level(n, 1);
		lower_roots[0] = solve_linear();
		for (int k = 2; k <= n; k++) begin
			form_level(n, k);
			upper_roots[0] = bisect(k, bound_lo, lower_roots[0]);
			for (int i = 1; i + 1 < k; i++)
				upper_roots[i] = bisect(k, lower_roots[i - 1], lower_roots[i]);
			upper_roots[k - 1] = bisect(k, lower_roots[k - 2], bound_hi);
			for (int i = 0; i < k; i++)
				lower_roots[i] = upper_roots[i];
		end
		for (int i = 0; i < n; i++) begin
			r.root = lower_roots[i][31:0];
			r.last = (i + 1 == n);
			r.bad  = 1'b0;
			root_q = {root_q, r};
		end
	endfunction

	function automatic void report(string what, logic [31:0] want, logic [31:0] got);
		n_fail++;
		if (n_fail <= 10)
			$display("mismatch at %0t: %s expected %h, got %h", $realtime, what, want, got);
	endfunction

	// All three channels are sampled at the rising edge.
	always @(posedge clk or negedge arst_n) begin
		root_result_t want;
		if (!arst_n) begin
			root_q.delete();
			coef_cnt = 0;
			bound_lo = longint'(ROOT_MIN_RST);
			bound_hi = longint'(ROOT_MAX_RST);
			stop_width = longint'(TOL_RST);
			n_fail = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					CFG_ROOT_MIN:  bound_lo = longint'($signed(cfg_data));
					CFG_ROOT_MAX:  bound_hi = longint'($signed(cfg_data));
					CFG_TOLERANCE: stop_width = longint'(cfg_data[20:0]);
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				take_coefficient(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (root_q.size() == 0) begin
					report("unexpected root transfer", 32'h0, m_tdata);
				end else begin
					want = root_q.pop_front();
					if (m_tdata !== want.root)
						report("root", want.root, m_tdata);
					if (m_tlast !== want.last)
						report("last_root", want.last, m_tlast);
					if (m_tuser !== want.bad)
						report("bad_input", want.bad, m_tuser);
				end
			end
		end
		fail_count <= n_fail;
		roots_pending <= root_q.size();
	end

endmodule

### tb/polynomial_real_root_finder_test.sv
// Top of the root finder testbench: clock, reset, coefficient and register
// stimulus, random back-pressure on the roots, and the verdict.
// Depends on prf_pkg, the block and prf_root_checker.
module polynomial_real_root_finder_test import prf_pkg::*;;

	localparam real Q24 = 16777216.0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tlast;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	int          fail_count;
	int          roots_pending;
	bit          no_idle = 1'b0;

	always #5 clk = ~clk;

	polynomial_real_root_finder i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	prf_root_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count), .roots_pending(roots_pending)
	);

	function automatic int draw_gap();
		return no_idle ? 0 : $urandom_range(0, 10);
	endfunction

	// Root receiver: a random stall before each transfer.
	initial begin
		int stall;
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && arst_n));
		end
	end

	task automatic send_coefficient(logic [31:0] data, logic is_last);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tlast  <= is_last;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_poly(logic [31:0] coefs[$]);
		foreach (coefs[i])
			send_coefficient(coefs[i], i == coefs.size() - 1);
	endtask

	// Drains the roots and lets the block settle before a register write.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (roots_pending != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Coefficients of a product of random real roots, scaled into Q8.24.
	function automatic void roots_poly(int deg, output logic [31:0] coefs[$]);
		real p[NCOEF];
		real r, peak, scale;
		longint q;
		p[0] = 1.0;
		for (int i = 1; i <= deg; i++)
			p[i] = 0.0;
		for (int k = 1; k <= deg; k++) begin
			r = (real'($urandom_range(0, 10000)) / 1000.0) - 5.0 + 0.37 * k;
			for (int i = k; i >= 1; i--)
				p[i] = p[i] - r * p[i - 1];
		end
		peak = 0.0;
		for (int i = 0; i <= deg; i++)
			if ((p[i] < 0 ? -p[i] : p[i]) > peak)
				peak = (p[i] < 0) ? -p[i] : p[i];
		scale = (real'($urandom_range(1, 100)) / peak) * Q24;
		if ($urandom_range(0, 1))
			scale = -scale;
		coefs.delete();
		for (int i = 0; i <= deg; i++) begin
			q = $rtoi(p[i] * scale);
			if (i == 0 && q == 0)
				q = 1;
			coefs = {coefs, q[31:0]};
		end
	endfunction

	// One random run: mostly well-formed, some raw noise and broken runs.
	task automatic random_run(inout int items);
		logic [31:0] coefs[$];
		int kind, deg;
		kind = $urandom_range(0, 99);
		deg = ($urandom_range(0, 9) == 0) ? $urandom_range(5, MAX_DEGREE)
			: $urandom_range(1, 4);
		if (kind < 75) begin
			roots_poly(deg, coefs);
		end else if (kind < 87) begin
			coefs.delete();
			for (int i = 0; i <= deg; i++)
				coefs = {coefs, 32'($urandom())};
			if (coefs[0] == 0)
				coefs[0] = 32'h1;
		end else if (kind < 92) begin
			roots_poly(deg, coefs);
			coefs[0] = '0;
		end else if (kind < 96) begin
			coefs = '{$urandom()};
		end else begin
			coefs.delete();
			for (int i = 0; i < $urandom_range(NCOEF + 1, NCOEF + 4); i++)
				coefs = {coefs, 32'($urandom())};
		end
		send_poly(coefs);
		items += coefs.size();
	endtask

	initial begin
		int items;
		logic [31:0] lo_set[6], hi_set[6], tol_set[6];
		lo_set  = '{-32'sd184549376, -32'sd184549376, 32'h8000_0000, 32'sd83886080,
			-32'sd50331648, -32'sd184549376};
		hi_set  = '{32'sd184549376, 32'sd184549376, 32'h7FFF_FFFF, -32'sd83886080,
			32'sd67108864, 32'sd184549376};
		tol_set = '{32'd0, 32'd1048576, 32'd1000, 32'd64, 32'd1, 32'd20000};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed runs with the reset bounds.
		send_poly('{32'h0100_0000});
		send_poly('{32'h0, 32'h0500_0000});
		send_poly('{32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000,
			32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000,
			32'h0100_0000, 32'h0100_0000});
		send_poly('{32'h0000_0001, 32'h8000_0000});
		send_poly('{32'h8000_0000, 32'h7FFF_FFFF});
		send_poly('{32'h0100_0000, 32'h0100_0000, 32'hFE00_0000});
		send_poly('{32'h7FFF_FFFF, 32'h0, 32'h8000_0000});

		// Random phases, each under its own register setting.
		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			write_reg(CFG_ROOT_MIN, lo_set[ph]);
			write_reg(CFG_ROOT_MAX, hi_set[ph]);
			write_reg(CFG_TOLERANCE, tol_set[ph]);
			items = 0;
			while (items < 70) begin
				no_idle = (ph == 2) || (ph == 4 && items < 30);
				random_run(items);
			end
		end
		no_idle = 1'b0;

		wait_idle();
		repeat (200) @(posedge clk);
		if (fail_count == 0 && roots_pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#200_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
